[hw/rtl/ssp_pkg.sv]
package ssp_pkg;

   // Q16.16 word width and fraction bits
   localparam int Q_W = 32;
   localparam int FRAC_W = 16;

   // configuration port
   localparam int CSR_IDX_W = 3;
   localparam int CSR_COUNT = 6;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PLAYER_POS_X = 3'd0,
      CSR_PLAYER_POS_Y = 3'd1,
      CSR_VIEW_DIR_X   = 3'd2,
      CSR_VIEW_DIR_Y   = 3'd3,
      CSR_CAM_PLANE_X  = 3'd4,
      CSR_CAM_PLANE_Y  = 3'd5
   } csr_idx_type;

   // inverse determinant sequencer
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DET  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_FIN  = 5'b10000
   } cam_state_type;

   localparam int INV_STEPS = 33;   // 2^32 numerator, one bit a step
   localparam int INV_CNT_W = 6;

   // pipelined divider sizing (covers the full parameter range)
   localparam int DIV_NW = 45;
   localparam int DIV_DW = 36;
   localparam int DIV_LANES = 4;
   localparam int LANE_SC = 0;
   localparam int LANE_VM = 1;
   localparam int LANE_H  = 2;
   localparam int LANE_W  = 3;

   // wide working width for bounds
   localparam int BW = 48;

   typedef struct packed {
      logic signed [Q_W-1:0] px;
      logic signed [Q_W-1:0] py;
      logic signed [Q_W-1:0] dx;
      logic signed [Q_W-1:0] dy;
      logic signed [Q_W-1:0] plx;
      logic signed [Q_W-1:0] ply;
      logic signed [Q_W-1:0] inv;
      logic                  det_zero;
   } cam_type;

   typedef struct packed {
      logic signed [Q_W-1:0] tx;
      logic signed [Q_W-1:0] ty;
      logic                  zero;
      logic                  sc_neg;
      logic                  vm_neg;
   } side_type;

   function automatic logic signed [Q_W-1:0] sat32(input logic signed [48:0] v);
      logic signed [Q_W-1:0] r;
      if (v > 49'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -49'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

   // floor(a / 2^16) - floor(b / 2^16), saturated
   function automatic logic signed [Q_W-1:0] qsub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [48:0] d;
      d = {a[63], a[63:FRAC_W]} - {b[63], b[63:FRAC_W]};
      return sat32(d);
   endfunction

endpackage

[hw/rtl/ssp_cam.sv]
module ssp_cam (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ssp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ssp_pkg::Q_W-1:0]          csr_data,
   output logic                             busy,
   output ssp_pkg::cam_type                 cam
);

   logic signed [31:0] px_ff, py_ff, dx_ff, dy_ff, plx_ff, ply_ff;
   logic signed [31:0] inv_ff;
   logic               det_zero_ff;
   ssp_pkg::cam_state_type state_ff, state_in;

   logic signed [63:0] pa_ff, pb_ff;
   logic [31:0]        rem_ff, rem_in, den_ff;
   logic [32:0]        nq_ff, nq_in;
   logic               neg_ff;
   logic [ssp_pkg::INV_CNT_W-1:0] cnt_ff;

   logic               cfg_wr;
   logic signed [31:0] det;
   logic [31:0]        det_mag;
   logic [32:0]        r;
   logic               ge;
   logic [33:0]        qext, qsgn;
   logic signed [31:0] inv_in;

   assign csr_ready = 1'b1;
   assign cfg_wr = csr_valid && (csr_index < ssp_pkg::CSR_IDX_W'(ssp_pkg::CSR_COUNT));
   assign busy = (state_ff != ssp_pkg::ST_IDLE);

   assign det = ssp_pkg::qsub(pa_ff, pb_ff);
   assign det_mag = det[31] ? (~det + 32'd1) : det;

   // restoring step
   always_comb begin
      r = {rem_ff, nq_ff[32]};
      ge = (r >= {1'b0, den_ff});
      rem_in = ge ? 32'(r - {1'b0, den_ff}) : r[31:0];
      nq_in = {nq_ff[31:0], ge};
   end

   always_comb begin
      qext = {1'b0, nq_ff};
      qsgn = neg_ff ? (~qext + 34'd1) : qext;
      if (!neg_ff && nq_ff > 33'h07FFFFFFF) begin
         inv_in = 32'sh7FFFFFFF;
      end else if (neg_ff && nq_ff > 33'h080000000) begin
         inv_in = 32'sh80000000;
      end else begin
         inv_in = qsgn[31:0];
      end
   end

   always_comb begin
      unique case (state_ff)
         ssp_pkg::ST_IDLE: state_in = ssp_pkg::ST_IDLE;
         ssp_pkg::ST_MUL:  state_in = ssp_pkg::ST_DET;
         ssp_pkg::ST_DET:  state_in = (det == 32'sd0) ? ssp_pkg::ST_IDLE : ssp_pkg::ST_DIV;
         ssp_pkg::ST_DIV:  state_in = (cnt_ff == '0) ? ssp_pkg::ST_FIN : ssp_pkg::ST_DIV;
         ssp_pkg::ST_FIN:  state_in = ssp_pkg::ST_IDLE;
         default:          state_in = ssp_pkg::ST_IDLE;
      endcase
      if (cfg_wr) begin
         state_in = ssp_pkg::ST_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff <= '0;
         py_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
         plx_ff <= '0;
         ply_ff <= '0;
         inv_ff <= 32'sh7FFFFFFF;
         det_zero_ff <= 1'b1;
         state_ff <= ssp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
         if (cfg_wr) begin
            unique case (ssp_pkg::csr_idx_type'(csr_index))
               ssp_pkg::CSR_PLAYER_POS_X: px_ff <= csr_data;
               ssp_pkg::CSR_PLAYER_POS_Y: py_ff <= csr_data;
               ssp_pkg::CSR_VIEW_DIR_X:   dx_ff <= csr_data;
               ssp_pkg::CSR_VIEW_DIR_Y:   dy_ff <= csr_data;
               ssp_pkg::CSR_CAM_PLANE_X:  plx_ff <= csr_data;
               ssp_pkg::CSR_CAM_PLANE_Y:  ply_ff <= csr_data;
               default: ;
            endcase
         end
         if (state_ff == ssp_pkg::ST_DET) begin
            det_zero_ff <= (det == 32'sd0);
            if (det == 32'sd0) begin
               inv_ff <= 32'sh7FFFFFFF;
            end
         end
         if (state_ff == ssp_pkg::ST_FIN) begin
            inv_ff <= inv_in;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == ssp_pkg::ST_MUL) begin
         pa_ff <= plx_ff * dy_ff;
         pb_ff <= dx_ff * ply_ff;
      end
      if (state_ff == ssp_pkg::ST_DET) begin
         den_ff <= det_mag;
         neg_ff <= det[31];
         rem_ff <= '0;
         nq_ff <= 33'h100000000;
         cnt_ff <= ssp_pkg::INV_CNT_W'(ssp_pkg::INV_STEPS - 1);
      end
      if (state_ff == ssp_pkg::ST_DIV) begin
         rem_ff <= rem_in;
         nq_ff <= nq_in;
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   always_comb begin
      cam.px = px_ff;
      cam.py = py_ff;
      cam.dx = dx_ff;
      cam.dy = dy_ff;
      cam.plx = plx_ff;
      cam.ply = ply_ff;
      cam.inv = inv_ff;
      cam.det_zero = det_zero_ff;
   end

endmodule

[hw/rtl/ssp_div.sv]
module ssp_div #(
   parameter int LANES = 4,
   parameter int NW = 45,
   parameter int DW = 36,
   parameter int SW = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [LANES-1:0][NW-1:0]    in_num,
   input  logic [LANES-1:0][DW-1:0]    in_den,
   input  logic [SW-1:0]               in_side,
   output logic                        out_valid,
   output logic [LANES-1:0][NW-1:0]    out_quo,
   output logic [SW-1:0]               out_side
);

   // one quotient bit per stage, restoring
   logic [NW-1:0]                       vld_ff;
   logic [NW-1:0][LANES-1:0][DW-1:0]    rem_ff, rem_in, den_ff;
   logic [NW-1:0][LANES-1:0][NW-1:0]    nq_ff, nq_in;
   logic [NW-1:0][SW-1:0]               side_ff;

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic                     src_vld;
      logic [LANES-1:0][DW-1:0] src_rem, src_den;
      logic [LANES-1:0][NW-1:0] src_nq;
      logic [SW-1:0]            src_side;

      if (k == 0) begin : g_first
         assign src_vld = in_valid;
         assign src_rem = '0;
         assign src_den = in_den;
         assign src_nq = in_num;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld = vld_ff[k-1];
         assign src_rem = rem_ff[k-1];
         assign src_den = den_ff[k-1];
         assign src_nq = nq_ff[k-1];
         assign src_side = side_ff[k-1];
      end

      for (genvar l = 0; l < LANES; l++) begin : g_lane
         logic [DW:0] r;
         logic        ge;
         always_comb begin
            r = {src_rem[l], src_nq[l][NW-1]};
            ge = (r >= {1'b0, src_den[l]});
            rem_in[k][l] = ge ? DW'(r - {1'b0, src_den[l]}) : r[DW-1:0];
            nq_in[k][l] = {src_nq[l][NW-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k] <= rem_in[k];
            nq_ff[k] <= nq_in[k];
            den_ff[k] <= src_den;
            side_ff[k] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[NW-1];
   assign out_quo = nq_ff[NW-1];
   assign out_side = side_ff[NW-1];

endmodule

[hw/rtl/sprite_screen_projection_top.sv]
// Sprite screen projection. Each word on the req_ channel is one sprite world
// position (Q16.16); one rsp_ word comes back for it, in order, carrying the
// camera-space position, centre column, vertical shift, pixel size and draw
// bounds. The pipeline takes one sprite per clock while req_stall is low; most
// of its register stages lie in the 45-stage radix-2 divider that forms
// column, shift, height and width in parallel lanes. After a write to one of
// the six camera registers on the csr_ port the inverse determinant of the
// camera matrix is rebuilt by a bit-serial divider, whose division is skipped
// when the new determinant is zero, and req_stall stays high meanwhile.
// Write the camera registers only with the pipeline empty.
module sprite_screen_projection_top #(
   parameter int SCREEN_WIDTH   = 640,
   parameter int SCREEN_HEIGHT  = 480,
   parameter int VERTICAL_MOVE  = 0,
   parameter int HEIGHT_DIVISOR = 1,
   parameter int WIDTH_DIVISOR  = 1
) (
   input  logic                          clock,
   input  logic                          reset,
   // sprite input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [31:0]            req_sprite_pos_x,
   input  logic signed [31:0]            req_sprite_pos_y,
   // projection result
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_cam_x,
   output logic signed [31:0]            rsp_cam_depth,
   output logic signed [15:0]            rsp_screen_column,
   output logic signed [15:0]            rsp_vertical_shift,
   output logic [14:0]                   rsp_sprite_height,
   output logic [14:0]                   rsp_sprite_width_px,
   output logic [14:0]                   rsp_first_row,
   output logic signed [15:0]            rsp_last_row,
   output logic [14:0]                   rsp_first_column,
   output logic signed [15:0]            rsp_last_column,
   output logic                          rsp_depth_zero,
   // camera registers
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ssp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data
);

   localparam int BW = ssp_pkg::BW;
   localparam int NW = ssp_pkg::DIV_NW;
   localparam int DW = ssp_pkg::DIV_DW;
   localparam int HALF_W = SCREEN_WIDTH / 2;
   localparam int HALF_H = SCREEN_HEIGHT / 2;
   localparam longint H_NUM = longint'(SCREEN_HEIGHT) * 65536;
   localparam longint VM_MAG = (VERTICAL_MOVE < 0) ? -longint'(VERTICAL_MOVE) * 65536
                                                   : longint'(VERTICAL_MOVE) * 65536;
   localparam logic VM_NEG = (VERTICAL_MOVE < 0);
   localparam longint VM_SAT = (VERTICAL_MOVE == 0) ? 0 :
                               ((VERTICAL_MOVE > 0) ? 32767 : -32768);

   function automatic logic signed [15:0] sat16(input logic signed [BW-1:0] v);
      logic signed [15:0] r;
      if (v > 48'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -48'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // value known non-negative or clamped at zero
   function automatic logic [14:0] sat15(input logic signed [BW-1:0] v);
      logic [14:0] r;
      if (v < 48'sd0) begin
         r = '0;
      end else if (v > 48'sd32767) begin
         r = 15'h7FFF;
      end else begin
         r = v[14:0];
      end
      return r;
   endfunction

   ssp_pkg::cam_type cam;
   logic             cam_busy;
   logic             adv, accept;
   logic             rsp_valid_ff;

   ssp_cam u_cam (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .busy      (cam_busy),
      .cam       (cam)
   );

   // whole pipe moves together whenever the output slot can take a word
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv || cam_busy;
   assign accept = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // ---- S1: position relative to the player
   logic               s1_vld_ff;
   logic signed [31:0] s1_rx_ff, s1_ry_ff, rx_in, ry_in;
   logic [32:0]        drx, dry;

   always_comb begin
      drx = {req_sprite_pos_x[31], req_sprite_pos_x} - {cam.px[31], cam.px};
      dry = {req_sprite_pos_y[31], req_sprite_pos_y} - {cam.py[31], cam.py};
      rx_in = ssp_pkg::sat32({{16{drx[32]}}, drx});
      ry_in = ssp_pkg::sat32({{16{dry[32]}}, dry});
   end

   // ---- S2: numerator products
   logic               s2_vld_ff;
   logic signed [63:0] s2_p0_ff, s2_p1_ff, s2_p2_ff, s2_p3_ff;

   // ---- S3: transform numerators
   logic               s3_vld_ff;
   logic signed [31:0] s3_numx_ff, s3_numy_ff;

   // ---- S4: scale by the inverse determinant
   logic               s4_vld_ff;
   logic signed [63:0] s4_px_ff, s4_py_ff;

   // ---- S5: camera-space coordinates
   logic               s5_vld_ff, s5_zero_ff;
   logic signed [31:0] s5_tx_ff, s5_ty_ff, tx_in, ty_in;

   assign tx_in = ssp_pkg::sat32({s4_px_ff[63], s4_px_ff[63:16]});
   assign ty_in = ssp_pkg::sat32({s4_py_ff[63], s4_py_ff[63:16]});

   // ---- S6: divider operands (magnitudes; signs ride alongside)
   logic                         s6_vld_ff;
   logic [ssp_pkg::DIV_LANES-1:0][NW-1:0] s6_num_ff, num_in;
   logic [ssp_pkg::DIV_LANES-1:0][DW-1:0] s6_den_ff, den_in;
   ssp_pkg::side_type            s6_side_ff, side_in;
   logic [31:0]                  aty;
   logic signed [32:0]           sum;
   logic signed [45:0]           nsc, msc;
   logic [DW-1:0]                aty_ext;

   always_comb begin
      aty = s5_ty_ff[31] ? (~s5_ty_ff + 32'd1) : s5_ty_ff;
      aty_ext = {{(DW-32){1'b0}}, aty};
      sum = {s5_tx_ff[31], s5_tx_ff} + {s5_ty_ff[31], s5_ty_ff};
      nsc = {{13{sum[32]}}, sum} * 46'(HALF_W);
      msc = nsc[45] ? (~nsc + 46'd1) : nsc;
      num_in[ssp_pkg::LANE_SC] = msc[NW-1:0];
      den_in[ssp_pkg::LANE_SC] = aty_ext;
      num_in[ssp_pkg::LANE_VM] = NW'(VM_MAG);
      den_in[ssp_pkg::LANE_VM] = aty_ext;
      num_in[ssp_pkg::LANE_H] = NW'(H_NUM);
      den_in[ssp_pkg::LANE_H] = aty_ext * DW'(HEIGHT_DIVISOR);
      num_in[ssp_pkg::LANE_W] = NW'(H_NUM);
      den_in[ssp_pkg::LANE_W] = aty_ext * DW'(WIDTH_DIVISOR);
      side_in.tx = s5_tx_ff;
      side_in.ty = s5_ty_ff;
      side_in.zero = s5_zero_ff;
      side_in.sc_neg = nsc[45] ^ s5_ty_ff[31];
      side_in.vm_neg = VM_NEG ^ s5_ty_ff[31];
   end

   // ---- divider lanes
   logic                         dv_vld;
   logic [ssp_pkg::DIV_LANES-1:0][NW-1:0] dv_quo;
   logic [$bits(ssp_pkg::side_type)-1:0]  dv_side_vec;
   ssp_pkg::side_type            dv_side;

   ssp_div #(
      .LANES (ssp_pkg::DIV_LANES),
      .NW    (NW),
      .DW    (DW),
      .SW    ($bits(ssp_pkg::side_type))
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s6_vld_ff),
      .in_num    (s6_num_ff),
      .in_den    (s6_den_ff),
      .in_side   (s6_side_ff),
      .out_valid (dv_vld),
      .out_quo   (dv_quo),
      .out_side  (dv_side_vec)
   );

   assign dv_side = ssp_pkg::side_type'(dv_side_vec);

   // ---- S7: signed results, zero-depth substitutes, raw bounds
   logic                  s7_vld_ff;
   ssp_pkg::side_type     s7_side_ff;
   logic signed [BW-1:0]  s7_sc_ff, s7_vm_ff, s7_h_ff, s7_w_ff;
   logic signed [BW-1:0]  s7_fr_ff, s7_lr_ff, s7_fc_ff, s7_lc_ff;
   logic signed [BW-1:0]  sc_in, vm_in, h_in, w_in;
   logic [BW-1:0]         qsc, qvm;

   // substitutes only for a zero depth; a singular matrix alone just flags
   always_comb begin
      qsc = {{(BW-NW){1'b0}}, dv_quo[ssp_pkg::LANE_SC]};
      qvm = {{(BW-NW){1'b0}}, dv_quo[ssp_pkg::LANE_VM]};
      if (dv_side.ty == 32'sd0) begin
         sc_in = dv_side.tx[31] ? -48'sd32768 : 48'sd32767;
         vm_in = BW'(VM_SAT);
         h_in = 48'sd32767;
         w_in = 48'sd32767;
      end else begin
         sc_in = dv_side.sc_neg ? (~qsc + 48'd1) : qsc;
         vm_in = dv_side.vm_neg ? (~qvm + 48'd1) : qvm;
         h_in = {{(BW-NW){1'b0}}, dv_quo[ssp_pkg::LANE_H]};
         w_in = {{(BW-NW){1'b0}}, dv_quo[ssp_pkg::LANE_W]};
      end
   end

   // ---- pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= dv_vld;
         rsp_valid_ff <= s7_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_rx_ff <= rx_in;
         s1_ry_ff <= ry_in;

         s2_p0_ff <= cam.dy * s1_rx_ff;
         s2_p1_ff <= cam.dx * s1_ry_ff;
         s2_p2_ff <= cam.plx * s1_ry_ff;
         s2_p3_ff <= cam.ply * s1_rx_ff;

         s3_numx_ff <= ssp_pkg::qsub(s2_p0_ff, s2_p1_ff);
         s3_numy_ff <= ssp_pkg::qsub(s2_p2_ff, s2_p3_ff);

         s4_px_ff <= cam.inv * s3_numx_ff;
         s4_py_ff <= cam.inv * s3_numy_ff;

         s5_tx_ff <= tx_in;
         s5_ty_ff <= ty_in;
         s5_zero_ff <= cam.det_zero || (ty_in == 32'sd0);

         s6_num_ff <= num_in;
         s6_den_ff <= den_in;
         s6_side_ff <= side_in;

         s7_side_ff <= dv_side;
         s7_sc_ff <= sc_in;
         s7_vm_ff <= vm_in;
         s7_h_ff <= h_in;
         s7_w_ff <= w_in;
         s7_fr_ff <= BW'(HALF_H) + vm_in - (h_in >>> 1);
         s7_lr_ff <= BW'(HALF_H) + vm_in + (h_in >>> 1);
         s7_fc_ff <= sc_in - (w_in >>> 1);
         s7_lc_ff <= sc_in + (w_in >>> 1);

         // output word: clamp bounds to the screen, saturate to field width
         rsp_cam_x <= s7_side_ff.tx;
         rsp_cam_depth <= s7_side_ff.ty;
         rsp_depth_zero <= s7_side_ff.zero;
         rsp_screen_column <= sat16(s7_sc_ff);
         rsp_vertical_shift <= sat16(s7_vm_ff);
         rsp_sprite_height <= sat15(s7_h_ff);
         rsp_sprite_width_px <= sat15(s7_w_ff);
         rsp_first_row <= sat15(s7_fr_ff);
         rsp_last_row <= (s7_lr_ff >= BW'(SCREEN_HEIGHT)) ? 16'(SCREEN_HEIGHT - 1)
                                                          : sat16(s7_lr_ff);
         rsp_first_column <= sat15(s7_fc_ff);
         rsp_last_column <= (s7_lc_ff >= BW'(SCREEN_WIDTH)) ? 16'(SCREEN_WIDTH - 1)
                                                            : sat16(s7_lc_ff);
      end
   end

endmodule
